[src/tat_pkg.sv]
// Package for the timestamp action table: table sizing, operation and status
// codes, and the packed item types of the command and result channels.
// Depends on nothing.
package tat_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = IDX_W + 1;

  localparam int OP_W     = 3;
  localparam int TIME_W   = 48;
  localparam int TAG_W    = 16;
  localparam int POS_W    = 6;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 7;
  localparam int ENTRY_W  = TIME_W + TAG_W;

  localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
  localparam logic [OP_W-1:0] OP_DELETE = 3'd1;
  localparam logic [OP_W-1:0] OP_COUNT  = 3'd2;
  localparam logic [OP_W-1:0] OP_SORT   = 3'd3;
  localparam logic [OP_W-1:0] OP_DUMP   = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_POS = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [TIME_W-1:0] time_value;
    logic [TAG_W-1:0]  payload_tag;
    logic [POS_W-1:0]  entry_position;
  } cmd_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  due_count;
    logic [TIME_W-1:0]   out_time;
    logic [TAG_W-1:0]    out_tag;
    logic [POS_W-1:0]    out_position;
    logic                last;
  } res_item_t;

  typedef struct packed {
    logic [TIME_W-1:0] stamp;
    logic [TAG_W-1:0]  tag;
  } entry_t;

endpackage

[src/tat_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing.
module tat_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[src/timestamp_action_table_top.sv]
// Top level of the timestamp action table: command sequencer around one entry RAM.
// Depends on tat_pkg and tat_ram.

// One command is taken at a time: start is accepted while busy is low. Insert
// and the rejected cases answer in the cycle after the transfer. Count due and
// dump read the entries one by one, and dump emits one entry per cycle, both
// paced by the single RAM read port. Delete moves each entry above the position
// one place down, a read and then a write. Sort is an insertion sort through the
// RAM. Results appear on out_item for exactly one cycle, marked by out_valid;
// the receiver cannot stall them. The table needs no clearing pass.
module timestamp_action_table_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  tat_pkg::cmd_item_t in_item,
  output logic               out_valid,
  output tat_pkg::res_item_t out_item
);
  import tat_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_DEL_RD = 9'b000000010,
    S_DEL_WR = 9'b000000100,
    S_COUNT  = 9'b000001000,
    S_DUMP   = 9'b000010000,
    S_SNEXT  = 9'b000100000,
    S_SKEY   = 9'b001000000,
    S_SCMP   = 9'b010000000,
    S_SPUT   = 9'b100000000
  } state_t;

  state_t      state_r, state_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic [IDX_W-1:0] j_r, j_nxt;
  logic        pend_r, pend_nxt;
  logic [CNT_W-1:0] acc_r, acc_nxt;
  logic [TIME_W-1:0] qtime_r, qtime_nxt;
  entry_t      key_r, key_nxt;
  logic        out_valid_r, out_valid_nxt;
  res_item_t   out_item_r, out_item_nxt;

  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  entry_t           wr_data;
  logic [IDX_W-1:0] rd_addr;
  entry_t           rd_data;

  tat_ram #(.DEPTH(TABLE_DEPTH), .WIDTH(ENTRY_W)) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  function automatic res_item_t single(logic [STATUS_W-1:0] st, logic [CNT_W-1:0] cnt);
    res_item_t r;
    r              = '0;
    r.status       = st;
    r.due_count    = COUNT_W'(cnt);
    r.last         = 1'b1;
    return r;
  endfunction

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    idx_nxt       = idx_r;
    j_nxt         = j_r;
    pend_nxt      = 1'b0;
    acc_nxt       = acc_r;
    qtime_nxt     = qtime_r;
    key_nxt       = key_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    wr_en         = 1'b0;
    wr_addr       = '0;
    wr_data       = key_r;
    rd_addr       = '0;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          qtime_nxt = in_item.time_value;
          unique case (in_item.operation)
            OP_INSERT: begin
              out_valid_nxt = 1'b1;
              if (fill_r >= CNT_W'(TABLE_DEPTH)) begin
                out_item_nxt = single(ST_FULL, fill_r);
              end else begin
                wr_en         = 1'b1;
                wr_addr       = IDX_W'(fill_r);
                wr_data.stamp = in_item.time_value;
                wr_data.tag   = in_item.payload_tag;
                fill_nxt      = fill_r + 1'b1;
                out_item_nxt  = single(ST_OK, fill_r + 1'b1);
              end
            end
            OP_DELETE: begin
              if (fill_r == '0) begin
                out_valid_nxt = 1'b1;
                out_item_nxt  = single(ST_EMPTY, '0);
              end else if (CNT_W'(in_item.entry_position) >= fill_r) begin
                out_valid_nxt = 1'b1;
                out_item_nxt  = single(ST_BAD_POS, fill_r);
              end else begin
                idx_nxt   = CNT_W'(in_item.entry_position);
                state_nxt = S_DEL_RD;
              end
            end
            OP_COUNT: begin
              idx_nxt   = '0;
              acc_nxt   = '0;
              state_nxt = S_COUNT;
            end
            OP_SORT: begin
              idx_nxt   = CNT_W'(1);
              state_nxt = S_SNEXT;
            end
            OP_DUMP: begin
              if (fill_r == '0) begin
                out_valid_nxt = 1'b1;
                out_item_nxt  = single(ST_EMPTY, '0);
              end else begin
                idx_nxt   = '0;
                state_nxt = S_DUMP;
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
              out_item_nxt  = single(ST_OK, fill_r);
            end
          endcase
        end
      end

      S_DEL_RD: begin
        if (idx_r + 1'b1 < fill_r) begin
          rd_addr   = IDX_W'(idx_r + 1'b1);
          state_nxt = S_DEL_WR;
        end else begin
          fill_nxt      = fill_r - 1'b1;
          out_valid_nxt = 1'b1;
          out_item_nxt  = single(ST_OK, fill_r - 1'b1);
          state_nxt     = S_IDLE;
        end
      end

      S_DEL_WR: begin
        wr_en     = 1'b1;
        wr_addr   = IDX_W'(idx_r);
        wr_data   = rd_data;
        idx_nxt   = idx_r + 1'b1;
        state_nxt = S_DEL_RD;
      end

      S_COUNT: begin
        if (pend_r && (rd_data.stamp <= qtime_r)) begin
          acc_nxt = acc_r + 1'b1;
        end
        if (idx_r < fill_r) begin
          rd_addr  = IDX_W'(idx_r);
          idx_nxt  = idx_r + 1'b1;
          pend_nxt = 1'b1;
        end else if (!pend_r) begin
          out_valid_nxt = 1'b1;
          out_item_nxt  = single(ST_OK, acc_r);
          state_nxt     = S_IDLE;
        end
      end

      S_DUMP: begin
        // The entry read last cycle is emitted while the next one is read.
        if (pend_r) begin
          out_valid_nxt             = 1'b1;
          out_item_nxt.status       = ST_OK;
          out_item_nxt.due_count    = COUNT_W'(fill_r);
          out_item_nxt.out_time     = rd_data.stamp;
          out_item_nxt.out_tag      = rd_data.tag;
          out_item_nxt.out_position = POS_W'(idx_r - 1'b1);
          out_item_nxt.last         = (idx_r == fill_r);
        end
        if (idx_r < fill_r) begin
          rd_addr  = IDX_W'(idx_r);
          idx_nxt  = idx_r + 1'b1;
          pend_nxt = 1'b1;
        end else if (pend_r) begin
          state_nxt = S_IDLE;
        end
      end

      S_SNEXT: begin
        if (idx_r < fill_r) begin
          rd_addr   = IDX_W'(idx_r);
          state_nxt = S_SKEY;
        end else begin
          out_valid_nxt = 1'b1;
          out_item_nxt  = single(ST_OK, fill_r);
          state_nxt     = S_IDLE;
        end
      end

      S_SKEY: begin
        key_nxt   = rd_data;
        j_nxt     = IDX_W'(idx_r);
        rd_addr   = IDX_W'(idx_r - 1'b1);
        state_nxt = S_SCMP;
      end

      S_SCMP: begin
        // rd_data holds the entry just below the hole at j.
        wr_en   = 1'b1;
        wr_addr = j_r;
        if (rd_data.stamp > key_r.stamp) begin
          wr_data = rd_data;
          j_nxt   = j_r - 1'b1;
          if (j_r == IDX_W'(1)) begin
            state_nxt = S_SPUT;
          end else begin
            rd_addr = j_r - IDX_W'(2);
          end
        end else begin
          wr_data   = key_r;
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_SNEXT;
        end
      end

      S_SPUT: begin
        wr_en     = 1'b1;
        wr_addr   = '0;
        wr_data   = key_r;
        idx_nxt   = idx_r + 1'b1;
        state_nxt = S_SNEXT;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
    idx_r      <= idx_nxt;
    j_r        <= j_nxt;
    acc_r      <= acc_nxt;
    qtime_r    <= qtime_nxt;
    key_r      <= key_nxt;
    out_item_r <= out_item_nxt;
  end

endmodule

[bench/tb_top.sv]
// Self-checking bench for the timestamp action table: commands driven through the
// start/busy handshake, results predicted in-bench and compared as they strobe out.
// Depends on tat_pkg and timestamp_action_table_top.
module tb_top;
  import tat_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  cmd_item_t in_item = '0;
  logic out_valid;
  res_item_t out_item;

  timestamp_action_table_top dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_item(in_item), .out_valid(out_valid), .out_item(out_item)
  );

  always #6 clk = ~clk;

  // Predictor state: a mirror of the table contents.
  logic [TIME_W-1:0] table_stamps[TABLE_DEPTH];
  logic [TAG_W-1:0]  table_tags[TABLE_DEPTH];
  int unsigned       table_fill;

  cmd_item_t pending_cmds[$];
  res_item_t expected_results[$];
  int  error_count = 0;
  int  idle_cycles = 0;
  bit  quiet_phase = 0;
  bit  cmd_taken = 0;
  int  send_gap = 0;

  function automatic res_item_t make_result(logic [STATUS_W-1:0] st, int unsigned cnt);
    res_item_t r;
    r = '0;
    r.status = st;
    r.due_count = cnt[COUNT_W-1:0];
    r.last = 1'b1;
    return r;
  endfunction

  task automatic predict_table_step(input cmd_item_t c);
    res_item_t r;
    int unsigned n;
    int j;
    logic [TIME_W-1:0] t;
    logic [TAG_W-1:0] g;
    case (c.operation)
      OP_INSERT: begin
        if (table_fill >= TABLE_DEPTH) begin
          expected_results.push_back(make_result(ST_FULL, table_fill));
        end else begin
          table_stamps[table_fill] = c.time_value;
          table_tags[table_fill] = c.payload_tag;
          table_fill++;
          expected_results.push_back(make_result(ST_OK, table_fill));
        end
      end
      OP_DELETE: begin
        if (table_fill == 0) begin
          expected_results.push_back(make_result(ST_EMPTY, 0));
        end else if (c.entry_position >= table_fill) begin
          expected_results.push_back(make_result(ST_BAD_POS, table_fill));
        end else begin
          for (int i = c.entry_position; i + 1 < table_fill; i++) begin
            table_stamps[i] = table_stamps[i+1];
            table_tags[i] = table_tags[i+1];
          end
          table_fill--;
          expected_results.push_back(make_result(ST_OK, table_fill));
        end
      end
      OP_COUNT: begin
        n = 0;
        for (int i = 0; i < table_fill; i++)
          if (table_stamps[i] <= c.time_value) n++;
        expected_results.push_back(make_result(ST_OK, n));
      end
      OP_SORT: begin
        for (int i = 1; i < table_fill; i++) begin
          t = table_stamps[i];
          g = table_tags[i];
          j = i;
          while (j > 0 && table_stamps[j-1] > t) begin
            table_stamps[j] = table_stamps[j-1];
            table_tags[j] = table_tags[j-1];
            j--;
          end
          table_stamps[j] = t;
          table_tags[j] = g;
        end
        expected_results.push_back(make_result(ST_OK, table_fill));
      end
      OP_DUMP: begin
        if (table_fill == 0) begin
          expected_results.push_back(make_result(ST_EMPTY, 0));
        end else begin
          for (int i = 0; i < table_fill; i++) begin
            r = make_result(ST_OK, table_fill);
            r.out_time = table_stamps[i];
            r.out_tag = table_tags[i];
            r.out_position = i[POS_W-1:0];
            r.last = (i + 1 == table_fill);
            expected_results.push_back(r);
          end
        end
      end
      default: expected_results.push_back(make_result(ST_OK, table_fill));
    endcase
  endtask

  function automatic cmd_item_t make_cmd(logic [OP_W-1:0] op, logic [TIME_W-1:0] tv,
                                         logic [TAG_W-1:0] tag, logic [POS_W-1:0] pos);
    cmd_item_t c;
    c.operation = op;
    c.time_value = tv;
    c.payload_tag = tag;
    c.entry_position = pos;
    return c;
  endfunction

  function automatic logic [TIME_W-1:0] random_stamp();
    logic [TIME_W-1:0] v;
    v = TIME_W'({$urandom, $urandom});
    case ($urandom_range(0, 3))
      0: v = TIME_W'($urandom_range(0, 7));   // many ties to exercise sort stability
      1: v = {TIME_W{1'b1}} - TIME_W'($urandom_range(0, 3));
      default: ;
    endcase
    return v;
  endfunction

  function automatic cmd_item_t random_cmd();
    int unsigned k;
    logic [OP_W-1:0] op;
    k = $urandom_range(0, 99);
    if (k < 40) op = OP_INSERT;
    else if (k < 58) op = OP_DELETE;
    else if (k < 72) op = OP_COUNT;
    else if (k < 82) op = OP_SORT;
    else if (k < 95) op = OP_DUMP;
    else op = OP_W'($urandom_range(5, 7));
    return make_cmd(op, random_stamp(), TAG_W'($urandom), POS_W'($urandom));
  endfunction

  // Driver: a transfer happens at the rising edge where start is high and busy low;
  // the monitor records it in cmd_taken.
  always @(negedge clk) begin
    if (rst_n) begin
      if (cmd_taken) begin
        void'(pending_cmds.pop_front());
        if (!quiet_phase && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 11);
      end
      if (send_gap > 0) begin
        send_gap--;
        start <= 1'b0;
      end else if (pending_cmds.size() > 0) begin
        start <= 1'b1;
        in_item <= pending_cmds[0];
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor and predictor feed, sampled at the rising edge.
  always @(posedge clk) begin
    res_item_t e;
    if (rst_n) begin
      cmd_taken <= (start && !busy);
      if ((start && !busy) || out_valid) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (start && !busy) begin
        predict_table_step(in_item);
      end
      if (out_valid) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result: %p", out_item);
          error_count++;
        end else begin
          e = expected_results.pop_front();
          if (out_item.status !== e.status) begin
            $error("status: expected %0d, actual %0d", e.status, out_item.status);
            error_count++;
          end
          if (out_item.due_count !== e.due_count) begin
            $error("due_count: expected %0d, actual %0d", e.due_count, out_item.due_count);
            error_count++;
          end
          if (out_item.out_time !== e.out_time) begin
            $error("out_time: expected %0h, actual %0h", e.out_time, out_item.out_time);
            error_count++;
          end
          if (out_item.out_tag !== e.out_tag) begin
            $error("out_tag: expected %0h, actual %0h", e.out_tag, out_item.out_tag);
            error_count++;
          end
          if (out_item.out_position !== e.out_position) begin
            $error("out_position: expected %0d, actual %0d", e.out_position,
                   out_item.out_position);
            error_count++;
          end
          if (out_item.last !== e.last) begin
            $error("last: expected %0b, actual %0b", e.last, out_item.last);
            error_count++;
          end
        end
      end
    end
  end

  // Watchdog and end of run.
  always @(posedge clk) begin
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    table_fill = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part: empty-table cases, extremes, every operation, full table.
    pending_cmds.push_back(make_cmd(OP_DELETE, '0, '0, '0));
    pending_cmds.push_back(make_cmd(OP_DUMP, '0, '0, '0));
    pending_cmds.push_back(make_cmd(OP_COUNT, {TIME_W{1'b1}}, '0, '0));
    pending_cmds.push_back(make_cmd(OP_SORT, '0, '0, '0));
    pending_cmds.push_back(make_cmd(3'd5, '0, '0, '0));
    pending_cmds.push_back(make_cmd(OP_INSERT, {TIME_W{1'b1}}, {TAG_W{1'b1}}, {POS_W{1'b1}}));
    pending_cmds.push_back(make_cmd(OP_INSERT, 48'd5, 16'h0001, '0));
    pending_cmds.push_back(make_cmd(OP_INSERT, 48'd5, 16'h0002, '0));
    pending_cmds.push_back(make_cmd(OP_INSERT, '0, '0, '0));
    pending_cmds.push_back(make_cmd(OP_COUNT, 48'd5, '0, '0));
    pending_cmds.push_back(make_cmd(OP_COUNT, '0, '0, '0));
    pending_cmds.push_back(make_cmd(OP_DELETE, '0, '0, 6'd4));
    pending_cmds.push_back(make_cmd(OP_DELETE, '0, '0, {POS_W{1'b1}}));
    pending_cmds.push_back(make_cmd(OP_SORT, '0, '0, '0));
    pending_cmds.push_back(make_cmd(OP_DUMP, '0, '0, '0));
    pending_cmds.push_back(make_cmd(OP_DELETE, '0, '0, 6'd1));
    pending_cmds.push_back(make_cmd(3'd6, '0, '0, '0));
    pending_cmds.push_back(make_cmd(3'd7, '0, '0, '0));
    for (int i = 0; i < TABLE_DEPTH - 2; i++)
      pending_cmds.push_back(make_cmd(OP_INSERT, random_stamp(), TAG_W'($urandom),
                                      POS_W'($urandom)));
    pending_cmds.push_back(make_cmd(OP_INSERT, 48'd1, 16'h5a5a, '0));
    pending_cmds.push_back(make_cmd(OP_DELETE, '0, '0, 6'd63));
    pending_cmds.push_back(make_cmd(OP_SORT, '0, '0, '0));
    pending_cmds.push_back(make_cmd(OP_DUMP, '0, '0, '0));
    for (int i = 0; i < 16; i++)
      pending_cmds.push_back(make_cmd(OP_DELETE, '0, '0, POS_W'($urandom_range(0, 1))));

    // Random part, the last stretch without gaps.
    for (int i = 0; i < 30; i++) pending_cmds.push_back(random_cmd());
    wait (pending_cmds.size() < 30);
    quiet_phase = 1;
    wait (pending_cmds.size() == 0 && !start);
    wait (expected_results.size() == 0);
    repeat (200) @(posedge clk);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
